/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/cgem_pkg.sv */
package cgem_pkg;

   localparam int FIELD_W = 63;

   localparam logic [1:0] ST_SOLVED   = 2'd0;
   localparam logic [1:0] ST_CONFLICT = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_RMOD,
      OP_CLEAR,
      OP_GINIT,
      OP_GSTEP,
      OP_A1G,
      OP_A2G,
      OP_M1G,
      OP_NG,
      OP_LCM,
      OP_DG,
      OP_DN,
      OP_EINIT,
      OP_EQ,
      OP_EM,
      OP_ER,
      OP_TM,
      OP_TR,
      OP_XM,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic   go;
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic done;
      logic y_zero;
      logic r1_zero;
      logic conflict;
      logic overflow;
      logic rsp_busy;
   } dp_status_type;

endpackage

/* design/cgem_div.sv */
module cgem_div #(
   parameter int W = 63
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] dividend,
   input  logic [W-1:0]   divisor,
   output logic           done,
   output logic [2*W-1:0] quot,
   output logic [W-1:0]   rem
);
   localparam int DCW = $clog2(2 * W + 1);

   logic [2*W-1:0] sh_ff, sh_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   dvs_ff;
   logic [DCW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [W:0]     trial;
   logic [W:0]     diff;
   logic           qbit;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      trial  = {rem_ff, sh_ff[2*W-1]};
      diff   = trial - {1'b0, dvs_ff};
      qbit   = (trial >= {1'b0, dvs_ff});
      rem_in = qbit ? diff[W-1:0] : trial[W-1:0];
      sh_in  = {sh_ff[2*W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCW'(2 * W);
            sh_ff   <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            sh_ff  <= sh_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = sh_ff;
   assign rem  = rem_ff;

endmodule

/* design/cgem_mul.sv */
module cgem_mul #(
   parameter int W = 63
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic           done,
   output logic [2*W-1:0] prod
);
   localparam int MCW = $clog2(W + 1);

   logic [2*W:0]   p_ff;
   logic [W-1:0]   a_ff;
   logic [MCW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [W:0]     sum;

   // Shift-add: the multiplier sits in the low half and shifts out as the
   // partial sum shifts in.
   assign sum = p_ff[2*W:W] + (p_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MCW'(W);
            a_ff    <= op_a;
            p_ff    <= {{(W + 1){1'b0}}, op_b};
         end else if (busy_ff) begin
            p_ff   <= {1'b0, sum, p_ff[W-1:1]};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == MCW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = p_ff[2*W-1:0];

endmodule

/* design/cgem_datapath.sv */
module cgem_datapath #(
   parameter int W = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cgem_pkg::ctl_cmd_type   cmd,
   output cgem_pkg::dp_status_type sts,
   input  logic                    load,
   input  logic [W-1:0]            in_res,
   input  logic [W-1:0]            in_mod,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [W-1:0]            rsp_sol,
   output logic [W-1:0]            rsp_cmod,
   output logic [1:0]              rsp_stat
);
   import cgem_pkg::*;

   logic [W-1:0]   a2_ff, m2_ff, mr_ff, mm_ff, x_ff, y_ff, tmp_ff, m1g_ff, n_ff;
   logic [W-1:0]   lcm_ff, d_ff, r0_ff, r1_ff, s0_ff, s1_ff, q_ff;
   logic [2*W-1:0] p_ff;
   logic           neg_ff, conf_ff, ovf_ff, done_ff, rsp_valid_ff;
   logic [W-1:0]   sol_ff, cmod_ff;
   logic [1:0]     stat_ff;

   logic           div_start, mul_start, simple_op;
   logic [2*W-1:0] div_a;
   logic [W-1:0]   div_b, mul_a, mul_b;
   logic           div_done, mul_done;
   logic [2*W-1:0] div_q, mul_p;
   logic [W-1:0]   div_r;
   logic [W-1:0]   diff;
   logic [1:0]     stat_now;

   assign diff = (a2_ff >= mr_ff) ? (a2_ff - mr_ff) : (mr_ff - a2_ff);
   assign stat_now = conf_ff ? ST_CONFLICT : (ovf_ff ? ST_OVERFLOW : ST_SOLVED);

   // Emission reports no completion: the controller is already idle and may
   // have started the next transaction.
   always_comb begin
      div_start = 1'b0;
      mul_start = 1'b0;
      simple_op = 1'b0;
      div_a     = '0;
      div_b     = x_ff;
      mul_a     = '0;
      mul_b     = '0;
      unique case (cmd.op)
         OP_RMOD:  begin div_start = cmd.go; div_a = (2*W)'(a2_ff);  div_b = m2_ff; end
         OP_GSTEP: begin div_start = cmd.go; div_a = (2*W)'(x_ff);   div_b = y_ff;  end
         OP_A1G:   begin div_start = cmd.go; div_a = (2*W)'(mr_ff);  end
         OP_A2G:   begin div_start = cmd.go; div_a = (2*W)'(a2_ff);  end
         OP_M1G:   begin div_start = cmd.go; div_a = (2*W)'(mm_ff);  end
         OP_NG:    begin div_start = cmd.go; div_a = (2*W)'(m2_ff);  end
         OP_DG:    begin div_start = cmd.go; div_a = (2*W)'(diff);   end
         OP_DN:    begin div_start = cmd.go; div_a = (2*W)'(d_ff);   div_b = n_ff;  end
         OP_EINIT: begin div_start = cmd.go; div_a = (2*W)'(m1g_ff); div_b = n_ff;  end
         OP_EQ:    begin div_start = cmd.go; div_a = (2*W)'(r0_ff);  div_b = r1_ff; end
         OP_ER:    begin div_start = cmd.go; div_a = p_ff;           div_b = n_ff;  end
         OP_TR:    begin div_start = cmd.go; div_a = p_ff;           div_b = n_ff;  end
         OP_LCM:   begin mul_start = cmd.go; mul_a = m1g_ff; mul_b = m2_ff; end
         OP_EM:    begin mul_start = cmd.go; mul_a = q_ff;   mul_b = s1_ff; end
         OP_TM:    begin mul_start = cmd.go; mul_a = d_ff;   mul_b = s0_ff; end
         OP_XM:    begin mul_start = cmd.go; mul_a = mm_ff;  mul_b = d_ff;  end
         OP_CLEAR, OP_GINIT: simple_op = cmd.go;
         default: ;
      endcase
   end

   cgem_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   cgem_mul #(.W(W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mr_ff        <= '0;
         mm_ff        <= W'(1);
         conf_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= simple_op || div_done || mul_done;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            a2_ff <= in_res;
            m2_ff <= (in_mod == '0) ? W'(1) : in_mod;
         end
         if (cmd.go) begin
            unique case (cmd.op)
               OP_CLEAR: begin
                  mr_ff   <= '0;
                  mm_ff   <= W'(1);
                  conf_ff <= 1'b0;
                  ovf_ff  <= 1'b0;
               end
               OP_GINIT: begin
                  x_ff <= mm_ff;
                  y_ff <= m2_ff;
               end
               OP_DG:    neg_ff <= (a2_ff < mr_ff);
               OP_EMIT: begin
                  rsp_valid_ff <= 1'b1;
                  stat_ff      <= stat_now;
                  sol_ff       <= (stat_now == ST_SOLVED) ? mr_ff : '0;
                  cmod_ff      <= (stat_now == ST_SOLVED) ? mm_ff : '0;
                  mr_ff        <= '0;
                  mm_ff        <= W'(1);
                  conf_ff      <= 1'b0;
                  ovf_ff       <= 1'b0;
               end
               default: ;
            endcase
         end
         if (div_done) begin
            unique case (cmd.op)
               OP_RMOD:  a2_ff <= div_r;
               OP_GSTEP: begin
                  x_ff <= y_ff;
                  y_ff <= div_r;
               end
               OP_A1G:   tmp_ff <= div_r;
               OP_A2G: begin
                  if (div_r != tmp_ff) begin
                     conf_ff <= 1'b1;
                  end
               end
               OP_M1G:   m1g_ff <= div_q[W-1:0];
               OP_NG:    n_ff <= div_q[W-1:0];
               OP_DG:    d_ff <= div_q[W-1:0];
               OP_DN:    d_ff <= (neg_ff && div_r != '0) ? (n_ff - div_r) : div_r;
               OP_EINIT: begin
                  r0_ff <= div_r;
                  r1_ff <= n_ff;
                  s0_ff <= W'(1);
                  s1_ff <= '0;
               end
               OP_EQ: begin
                  q_ff  <= div_q[W-1:0];
                  r0_ff <= r1_ff;
                  r1_ff <= div_r;
               end
               OP_ER: begin
                  s0_ff <= s1_ff;
                  s1_ff <= (s0_ff >= div_r) ? (s0_ff - div_r) : (s0_ff + n_ff - div_r);
               end
               OP_TR:    d_ff <= div_r;
               default: ;
            endcase
         end
         if (mul_done) begin
            unique case (cmd.op)
               OP_LCM: begin
                  if (mul_p[2*W-1:W] != '0) begin
                     ovf_ff <= 1'b1;
                  end
                  lcm_ff <= mul_p[W-1:0];
               end
               OP_EM, OP_TM: p_ff <= mul_p;
               OP_XM: begin
                  mr_ff <= mr_ff + mul_p[W-1:0];
                  mm_ff <= lcm_ff;
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      sts.done     = done_ff;
      sts.y_zero   = (y_ff == '0);
      sts.r1_zero  = (r1_ff == '0);
      sts.conflict = conf_ff;
      sts.overflow = ovf_ff;
      sts.rsp_busy = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sol   = sol_ff;
   assign rsp_cmod  = cmod_ff;
   assign rsp_stat  = stat_ff;

endmodule

/* design/cgem_ctrl.sv */
module cgem_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_first,
   input  logic                    req_last,
   output cgem_pkg::ctl_cmd_type   cmd,
   input  cgem_pkg::dp_status_type sts
);
   import cgem_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      go_ff;
   op_type    op_ff;
   logic      first_ff, last_ff;
   op_type    nxt;

   // Next step of the merge once the current one has written back.
   function automatic op_type next_op(op_type op, dp_status_type s, logic first);
      op_type r;
      r = OP_NONE;
      unique case (op)
         OP_RMOD:  r = first ? OP_CLEAR : ((s.conflict || s.overflow) ? OP_NONE : OP_GINIT);
         OP_CLEAR: r = OP_GINIT;
         OP_GINIT: r = OP_GSTEP;
         OP_GSTEP: r = s.y_zero ? OP_A1G : OP_GSTEP;
         OP_A1G:   r = OP_A2G;
         OP_A2G:   r = s.conflict ? OP_NONE : OP_M1G;
         OP_M1G:   r = OP_NG;
         OP_NG:    r = OP_LCM;
         OP_LCM:   r = s.overflow ? OP_NONE : OP_DG;
         OP_DG:    r = OP_DN;
         OP_DN:    r = OP_EINIT;
         OP_EINIT: r = s.r1_zero ? OP_TM : OP_EQ;
         OP_EQ:    r = OP_EM;
         OP_EM:    r = OP_ER;
         OP_ER:    r = s.r1_zero ? OP_TM : OP_EQ;
         OP_TM:    r = OP_TR;
         OP_TR:    r = OP_XM;
         default:  r = OP_NONE;
      endcase
      return r;
   endfunction

   assign nxt = next_op(op_ff, sts, first_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
         op_ff    <= OP_NONE;
         first_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  first_ff <= req_first;
                  last_ff  <= req_last;
                  op_ff    <= OP_RMOD;
                  go_ff    <= 1'b1;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (sts.done) begin
                  if (nxt == OP_NONE) begin
                     state_ff <= last_ff ? S_EMIT : S_IDLE;
                  end else begin
                     op_ff <= nxt;
                     go_ff <= 1'b1;
                  end
               end
            end
            S_EMIT: begin
               if (!sts.rsp_busy) begin
                  op_ff    <= OP_EMIT;
                  go_ff    <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign cmd.go    = go_ff;
   assign cmd.op    = op_ff;

endmodule

/* design/crt_general_equation_merger.sv */
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    residue, modulus, first, last
// rsp       out        rsp_valid/ready    solution, combined_modulus, status
//
// Each division runs on the shared divider and each product on the multiplier, while the
// bookkeeping steps use neither. A congruence starts in the cycle after it is
// accepted and runs the residue reduction, one division per gcd step, eight more
// divisions, three products, and two divisions and one product per inverse step.
// A conflict or overflow ends the run early; req_ready is high only while idle.
// Synchronous reset returns the merge state to x = 0 mod 1. A waiting result does not
// stop the next congruence; only the next emission waits for it to leave.
`include "assert_macros.svh"

module crt_general_equation_merger #(
   parameter int VALUE_WIDTH = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cgem_pkg::FIELD_W-1:0] req_residue,
   input  logic [cgem_pkg::FIELD_W-1:0] req_modulus,
   input  logic                         req_first_equation,
   input  logic                         req_last_equation,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cgem_pkg::FIELD_W-1:0] rsp_solution,
   output logic [cgem_pkg::FIELD_W-1:0] rsp_combined_modulus,
   output logic [1:0]                   rsp_status
);
   import cgem_pkg::*;

   ctl_cmd_type            cmd;
   dp_status_type          sts;
   logic [VALUE_WIDTH-1:0] sol, cmod;
   logic                   load;

   assign load = req_valid && req_ready;

   cgem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_first (req_first_equation),
      .req_last  (req_last_equation),
      .cmd       (cmd),
      .sts       (sts)
   );

   cgem_datapath #(.W(VALUE_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .load      (load),
      .in_res    (req_residue[VALUE_WIDTH-1:0]),
      .in_mod    (req_modulus[VALUE_WIDTH-1:0]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_sol   (sol),
      .rsp_cmod  (cmod),
      .rsp_stat  (rsp_status)
   );

   assign rsp_solution         = FIELD_W'(sol);
   assign rsp_combined_modulus = FIELD_W'(cmod);

   `ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_SOLVED, rsp_solution == '0 && rsp_combined_modulus == '0)
   `ASSERT_IMPL(a_sol_range, clock, reset, rsp_valid && rsp_status == ST_SOLVED, rsp_solution < rsp_combined_modulus)
   `ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready)

endmodule

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cgem_pkg::*;

   localparam logic [63:0] VMASK = 64'h7fff_ffff_ffff_ffff;
   localparam int DRAIN_PAUSE = 400;
   localparam int TAIL_QUIET = 80;

   typedef struct {
      logic [FIELD_W-1:0] residue;
      logic [FIELD_W-1:0] modulus;
      logic               first_eq;
      logic               last_eq;
      bit                 drain;
   } congruence_type;

   typedef struct {
      logic [FIELD_W-1:0] solution;
      logic [FIELD_W-1:0] lcm;
      logic [1:0]         status;
   } solution_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [FIELD_W-1:0] req_residue;
   logic [FIELD_W-1:0] req_modulus;
   logic               req_first_equation;
   logic               req_last_equation;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [FIELD_W-1:0] rsp_solution;
   logic [FIELD_W-1:0] rsp_combined_modulus;
   logic [1:0]         rsp_status;

   congruence_type pending_eqs[$];
   solution_type   expected_solutions[$];
   int             mismatch_count = 0;
   bit             stimulus_done = 1'b0;

   // Running merge held by the predictor.
   logic [63:0] sys_residue = 64'd0;
   logic [63:0] sys_modulus = 64'd1;
   bit          sys_conflict = 1'b0;
   bit          sys_overflow = 1'b0;

   crt_general_equation_merger i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_residue          (req_residue),
      .req_modulus          (req_modulus),
      .req_first_equation   (req_first_equation),
      .req_last_equation    (req_last_equation),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_solution         (rsp_solution),
      .rsp_combined_modulus (rsp_combined_modulus),
      .rsp_status           (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [62:0] rand63();
      return 63'({$urandom, $urandom});
   endfunction

   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
      logic [127:0] p;
      p = {64'd0, a % n} * {64'd0, b % n};
      return 64'(p % {64'd0, n});
   endfunction

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Modular inverse by extended Euclid with the coefficient kept modulo n.
   function automatic logic [63:0] invmod(logic [63:0] a, logic [63:0] n);
      logic [63:0] r0, r1, s0, s1, q, rt, st, qs;
      if (n == 1) return 64'd0;
      r0 = a % n;
      r1 = n;
      s0 = 64'd1;
      s1 = 64'd0;
      while (r1 != 0) begin
         q = r0 / r1;
         rt = r0 - q * r1;
         qs = mulmod(q, s1, n);
         st = (s0 >= qs) ? s0 - qs : s0 + (n - qs);
         r0 = r1;
         r1 = rt;
         s0 = s1;
         s1 = st;
      end
      return s0 % n;
   endfunction

   task automatic fold_congruence(logic [63:0] a2, logic [63:0] m2);
      logic [63:0] a1, m1, g, m1g, n, d, t;
      a1 = sys_residue;
      m1 = (sys_modulus == 0) ? 64'd1 : sys_modulus;
      a1 = a1 % m1;
      g = gcd64(m1, m2);
      if ((a1 % g) != (a2 % g)) begin
         sys_conflict = 1'b1;
         return;
      end
      m1g = m1 / g;
      n = m2 / g;
      if (m1g > VMASK / m2) begin
         sys_overflow = 1'b1;
         return;
      end
      if (a2 >= a1) d = ((a2 - a1) / g) % n;
      else begin
         d = ((a1 - a2) / g) % n;
         d = (d == 0) ? 64'd0 : n - d;
      end
      t = mulmod(d, invmod(m1g, n), n);
      sys_residue = a1 + m1 * t;
      sys_modulus = m1g * m2;
   endtask

   task automatic clear_system();
      sys_residue = 64'd0;
      sys_modulus = 64'd1;
      sys_conflict = 1'b0;
      sys_overflow = 1'b0;
   endtask

   task automatic predict_congruence(congruence_type eq);
      logic [63:0]  r, m;
      solution_type sol;
      m = {1'b0, eq.modulus};
      if (m == 0) m = 64'd1;
      r = {1'b0, eq.residue} % m;
      if (eq.first_eq) clear_system();
      if (!sys_conflict && !sys_overflow) fold_congruence(r, m);
      if (eq.last_eq) begin
         sol.status = sys_conflict ? ST_CONFLICT : (sys_overflow ? ST_OVERFLOW : ST_SOLVED);
         sol.solution = (sol.status == ST_SOLVED) ? sys_residue[62:0] : '0;
         sol.lcm = (sol.status == ST_SOLVED) ? sys_modulus[62:0] : '0;
         expected_solutions = {expected_solutions, sol};
         clear_system();
      end
   endtask

   task automatic add_eq(logic [62:0] r, logic [62:0] m, bit f, bit l, bit drain = 1'b0);
      congruence_type eq;
      eq.residue = r;
      eq.modulus = m;
      eq.first_eq = f;
      eq.last_eq = l;
      eq.drain = drain;
      pending_eqs = {pending_eqs, eq};
   endtask

   // Mostly narrow moduli keep the Euclid runs short; a few are wider, up to the full width.
   function automatic logic [62:0] rand_modulus();
      int w;
      if ($urandom_range(0, 29) == 0) return '0;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 63) : $urandom_range(1, 16);
      return rand63() >> (63 - w);
   endfunction

   initial begin
      logic [62:0] x, m;
      int          len;
      bit          consistent;
      reset = 1'b1;
      // Directed part.
      add_eq(VMASK[62:0], VMASK[62:0], 1'b1, 1'b1);
      add_eq('0, 63'd1, 1'b1, 1'b1);
      add_eq(63'd12345, '0, 1'b1, 1'b1);
      add_eq(63'd100, 63'd7, 1'b1, 1'b1);
      add_eq(63'd2, 63'd3, 1'b1, 1'b0);
      add_eq(63'd3, 63'd5, 1'b0, 1'b0);
      add_eq(63'd2, 63'd7, 1'b0, 1'b1);
      add_eq(63'd1, 63'd4, 1'b1, 1'b0);
      add_eq(63'd3, 63'd6, 1'b0, 1'b1);
      add_eq(63'd0, 63'd2, 1'b1, 1'b0);
      add_eq(63'd1, 63'd4, 1'b0, 1'b0);
      add_eq(63'd5, 63'd9, 1'b0, 1'b1);
      add_eq(63'd5, VMASK[62:0], 1'b1, 1'b0);
      add_eq(63'd7, VMASK[62:0] - 63'd1, 1'b0, 1'b0);
      add_eq(63'd1, 63'd3, 1'b0, 1'b1);
      add_eq(63'd4, 63'd9, 1'b0, 1'b0);
      add_eq(63'd1, 63'd10, 1'b0, 1'b1);
      add_eq(63'd9, 63'd11, 1'b1, 1'b0);
      add_eq(63'd3, 63'd13, 1'b1, 1'b1, 1'b1);
      add_eq(63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaab, 1'b1, 1'b1);
      // Random systems.
      while (pending_eqs.size() < 720) begin
         if ($urandom_range(0, 19) == 0) begin
            add_eq(rand63(), rand_modulus(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
            continue;
         end
         len = $urandom_range(1, 5);
         consistent = ($urandom_range(0, 4) != 0);
         x = rand63();
         for (int i = 0; i < len; i++) begin
            m = rand_modulus();
            add_eq(consistent ? ($urandom_range(0, 1) ? x : x % (m == 0 ? 63'd1 : m))
                              : rand63() >> $urandom_range(0, 62),
                   m, (i == 0) && ($urandom_range(0, 9) != 0), i == len - 1,
                   pending_eqs.size() == 400);
         end
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender.
   int gap_left = 0;
   int drain_wait = 0;
   always @(posedge clock) begin
      logic           next_valid;
      congruence_type eq;
      if (reset) begin
         req_valid <= 1'b0;
         req_residue <= '0;
         req_modulus <= '0;
         req_first_equation <= 1'b0;
         req_last_equation <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            eq.residue = req_residue;
            eq.modulus = req_modulus;
            eq.first_eq = req_first_equation;
            eq.last_eq = req_last_equation;
            eq.drain = 1'b0;
            predict_congruence(eq);
            next_valid = 1'b0;
            if (pending_eqs.size() > TAIL_QUIET && $urandom_range(0, 2) == 0)
               gap_left = $urandom_range(1, 7);
         end
         if (!next_valid) begin
            if (gap_left > 0) gap_left--;
            else if (pending_eqs.size() != 0) begin
               if (pending_eqs[0].drain && expected_solutions.size() != 0) drain_wait = 0;
               else if (pending_eqs[0].drain && drain_wait < DRAIN_PAUSE) drain_wait++;
               else begin
                  eq = pending_eqs.pop_front();
                  req_residue <= eq.residue;
                  req_modulus <= eq.modulus;
                  req_first_equation <= eq.first_eq;
                  req_last_equation <= eq.last_eq;
                  next_valid = 1'b1;
               end
            end else stimulus_done = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: stalls come in bursts, and stop near the end.
   int stall_left = 0;
   always @(posedge clock) begin
      solution_type want;
      if (reset) rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_solutions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: solution %0d modulus %0d status %0d",
                           rsp_solution, rsp_combined_modulus, rsp_status);
            end else begin
               want = expected_solutions.pop_front();
               if (rsp_solution !== want.solution || rsp_combined_modulus !== want.lcm
                   || rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result differs: solution %0d/%0d modulus %0d/%0d status %0d/%0d",
                              want.solution, rsp_solution, want.lcm, rsp_combined_modulus,
                              want.status, rsp_status);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (pending_eqs.size() > TAIL_QUIET && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_solutions.size() == 0);
      repeat (40000) @(posedge clock);
      if (mismatch_count == 0 && expected_solutions.size() == 0)
         $display("crt_general_equation_merger: match");
      else
         $display("crt_general_equation_merger: mismatch");
      $finish;
   end

   initial begin
      #500ms;
      $display("crt_general_equation_merger: mismatch");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/cgem_pkg.sv
design/cgem_div.sv
design/cgem_mul.sv
design/cgem_datapath.sv
design/cgem_ctrl.sv
design/crt_general_equation_merger.sv
test/tb_top.sv
